// ===== rtl/core/dnle_pkg.sv =====
// ----------------------------------------------------------------------------
// dnle_pkg: shared constants and types for the DNS name label encoder
// Default sizes, command codes and the label buffer write bundle.
// ----------------------------------------------------------------------------
package dnle_pkg;

    localparam int LABEL_MAX_DEF = 62;
    localparam int NAME_MAX_DEF  = 255;

    localparam logic       CMD_CHAR = 1'b0;
    localparam logic       CMD_END  = 1'b1;
    localparam logic [7:0] DOT_CHAR = 8'h2E;

    typedef struct packed {
        logic       en;
        logic [7:0] data;
    } t_wr_ctl;

endpackage

// ===== rtl/core/dnle_label_buf.sv =====
// ----------------------------------------------------------------------------
// dnle_label_buf: label character buffer
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module dnle_label_buf #(
    parameter int DEPTH = dnle_pkg::LABEL_MAX_DEF,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  dnle_pkg::t_wr_ctl i_wr,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [7:0]        o_rd_data
);
    import dnle_pkg::*;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/dnle_seq.sv =====
// ----------------------------------------------------------------------------
// dnle_seq: label sequencer
// Buffers characters, then drains a label one byte per cycle, when not stalled,
// through the output register; one saturating adder keeps the running name length.
// ----------------------------------------------------------------------------
module dnle_seq #(
    parameter int LABEL_MAX = dnle_pkg::LABEL_MAX_DEF,
    parameter int NAME_MAX  = dnle_pkg::NAME_MAX_DEF,
    parameter int CW        = 6,
    parameter int AW        = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_command,
    input  logic [7:0]        i_char_code,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_name_done,
    output logic [7:0]        o_encoded_length,
    output logic              o_error,
    output dnle_pkg::t_wr_ctl o_wr,
    output logic [AW-1:0]     o_wr_addr,
    output logic [AW-1:0]     o_rd_addr,
    input  logic [7:0]        i_rd_data
);
    import dnle_pkg::*;

    localparam int TW = $clog2(NAME_MAX + 2);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LEN  = 2'd1;
    localparam logic [1:0] S_CHAR = 2'd2;
    localparam logic [1:0] S_ZERO = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_lcnt, n_lcnt;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_is_end, n_is_end;
    logic [TW-1:0] r_total, n_total;
    logic          r_ovf, n_ovf;

    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_byte, n_out_byte;
    logic          r_out_done, n_out_done;
    logic [7:0]    r_out_len, n_out_len;
    logic          r_out_err, n_out_err;

    logic          slot;
    logic          accept;
    logic          is_flush;
    logic [TW:0]   addend;
    logic [TW:0]   sum;
    logic [TW-1:0] sat_total;
    logic          over_name;

    assign slot     = !r_out_valid || !i_out_stall;
    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign is_flush = (i_command == CMD_END) || (i_char_code == DOT_CHAR);

    // shared saturating adder: label length plus its length byte, or the terminator
    always_comb begin
        addend = (r_state == S_LEN) ? ((TW+1)'(r_n) + (TW+1)'(1)) : (TW+1)'(1);
        sum    = {1'b0, r_total} + addend;
        if (sum > (TW+1)'(NAME_MAX + 1)) begin
            sat_total = TW'(NAME_MAX + 1);
        end else begin
            sat_total = sum[TW-1:0];
        end
        over_name = (sat_total > TW'(NAME_MAX));
    end

    always_comb begin
        n_state     = r_state;
        n_lcnt      = r_lcnt;
        n_n         = r_n;
        n_idx       = r_idx;
        n_is_end    = r_is_end;
        n_total     = r_total;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_done  = r_out_done;
        n_out_len   = r_out_len;
        n_out_err   = r_out_err;
        o_wr.en     = 1'b0;
        o_wr.data   = i_char_code;

        if (slot) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (is_flush) begin
                        n_n      = r_lcnt;
                        n_lcnt   = '0;
                        n_idx    = '0;
                        n_is_end = (i_command == CMD_END);
                        n_state  = S_LEN;
                    end else if (r_lcnt < CW'(LABEL_MAX)) begin
                        o_wr.en = 1'b1;
                        n_lcnt  = r_lcnt + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            S_LEN: begin
                if (slot) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = 8'(r_n);
                    n_out_done  = 1'b0;
                    n_out_len   = '0;
                    n_out_err   = 1'b0;
                    n_total     = sat_total;
                    if (r_n != '0) begin
                        n_state = S_CHAR;
                    end else if (r_is_end) begin
                        n_state = S_ZERO;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_CHAR: begin
                if (slot) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = i_rd_data;
                    n_out_done  = 1'b0;
                    n_out_len   = '0;
                    n_out_err   = 1'b0;
                    n_idx       = r_idx + CW'(1);
                    if (n_idx == r_n) begin
                        n_state = r_is_end ? S_ZERO : S_IDLE;
                    end
                end
            end
            S_ZERO: begin
                if (slot) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = '0;
                    n_out_done  = 1'b1;
                    n_out_len   = over_name ? 8'(NAME_MAX) : 8'(sat_total);
                    n_out_err   = r_ovf || over_name;
                    n_total     = '0;
                    n_ovf       = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lcnt      <= '0;
            r_n         <= '0;
            r_idx       <= '0;
            r_is_end    <= 1'b0;
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lcnt      <= n_lcnt;
            r_n         <= n_n;
            r_idx       <= n_idx;
            r_is_end    <= n_is_end;
            r_total     <= n_total;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_done <= n_out_done;
        r_out_len  <= n_out_len;
        r_out_err  <= n_out_err;
    end

    // read address runs one step ahead so the registered data lines up with r_idx
    assign o_rd_addr        = n_idx[AW-1:0];
    assign o_wr_addr        = r_lcnt[AW-1:0];
    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_name_done      = r_out_done;
    assign o_encoded_length = r_out_len;
    assign o_error          = r_out_err;

endmodule

// ===== rtl/core/dns_name_label_encoder.sv =====
// ----------------------------------------------------------------------------
// dns_name_label_encoder: dotted name to DNS wire form
// Buffers one label, then writes its length byte and characters; end of
// name adds the zero byte with total length and error flag.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  input   | i_in_valid / o_in_stall   | i_command, i_char_code
//  output  | o_out_valid / i_out_stall | o_out_byte, o_name_done,
//          |                           | o_encoded_length, o_error
//
//  a character item is taken without raising o_in_stall and produces nothing
//  a dot with n buffered characters sends its length byte and the n characters;
//  an end of name adds the zero byte; the sequencer writes one byte per cycle to the
//  output register when not stalled; o_in_stall stays high until the label drains
//  synchronous active-low reset clears the label count, name length and overflow flag
// ----------------------------------------------------------------------------
module dns_name_label_encoder #(
    parameter int LABEL_MAX = dnle_pkg::LABEL_MAX_DEF,
    parameter int NAME_MAX  = dnle_pkg::NAME_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_command,
    input  logic [7:0] i_char_code,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_name_done,
    output logic [7:0] o_encoded_length,
    output logic       o_error
);
    import dnle_pkg::*;

    localparam int CW = $clog2(LABEL_MAX + 1);
    localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

    t_wr_ctl       wr;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    dnle_label_buf #(
        .DEPTH (LABEL_MAX),
        .AW    (AW)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_wr_addr (wr_addr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    dnle_seq #(
        .LABEL_MAX (LABEL_MAX),
        .NAME_MAX  (NAME_MAX),
        .CW        (CW),
        .AW        (AW)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_char_code      (i_char_code),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_byte       (o_out_byte),
        .o_name_done      (o_name_done),
        .o_encoded_length (o_encoded_length),
        .o_error          (o_error),
        .o_wr             (wr),
        .o_wr_addr        (wr_addr),
        .o_rd_addr        (rd_addr),
        .i_rd_data        (rd_data)
    );

endmodule

// ===== rtl/core/dnle_checker.sv =====
// ----------------------------------------------------------------------------
// dnle_checker: port-level checks for the DNS name label encoder
// Watches both channels and the terminator fields over time.
// ----------------------------------------------------------------------------
module dnle_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       i_command,
    input logic [7:0] i_char_code,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_name_done,
    input logic [7:0] o_encoded_length,
    input logic       o_error
);
    import dnle_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_name_done))
        else $error("stalled output item changed");

    // end of name always starts a drain
    a_end_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_command == CMD_END) |=> o_in_stall)
        else $error("end of name did not start a drain");

    // terminator is a zero byte and counts at least itself
    a_term_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_name_done |-> (o_out_byte == 8'd0) && (o_encoded_length != 8'd0))
        else $error("bad terminator item");

    // length and error only on the terminator
    a_mid_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_name_done |-> (o_encoded_length == 8'd0) && !o_error)
        else $error("length or error on a non-terminator item");

    // a plain character never stalls the input side
    a_char_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_command == CMD_CHAR) && (i_char_code != DOT_CHAR)
            |=> !o_in_stall)
        else $error("character item stalled the input");

endmodule

bind dns_name_label_encoder dnle_checker u_dnle_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .i_command        (i_command),
    .i_char_code      (i_char_code),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_out_byte       (o_out_byte),
    .o_name_done      (o_name_done),
    .o_encoded_length (o_encoded_length),
    .o_error          (o_error)
);

// ===== test/dns_name_wire_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dns_name_wire_checker: predicts and checks the encoded byte stream
// Watches both channels of the label encoder, builds the expected wire-form
// bytes for each accepted item and compares every accepted result in order.
// ----------------------------------------------------------------------------
module dns_name_wire_checker #(
    parameter int LABEL_MAX = dnle_pkg::LABEL_MAX_DEF,
    parameter int NAME_MAX  = dnle_pkg::NAME_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic       i_command,
    input  logic [7:0] i_char_code,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_out_byte,
    input  logic       i_name_done,
    input  logic [7:0] i_encoded_length,
    input  logic       i_error,
    output int         o_fail_count,
    output int         o_expected_left,
    output int         o_bytes_checked
);
    import dnle_pkg::*;

    typedef struct packed {
        logic [7:0] code;
        logic       done;
        logic [7:0] length;
        logic       err;
    } t_wire_byte;

    t_wire_byte  wire_q[$];
    logic [7:0]  label_chars [LABEL_MAX];
    int unsigned label_len;
    int unsigned name_bytes;
    logic        label_overflow;
    int          fail_count;
    int          bytes_checked;

    initial begin
        o_fail_count    = 0;
        o_expected_left = 0;
        o_bytes_checked = 0;
        fail_count      = 0;
        bytes_checked   = 0;
        label_len       = 0;
        name_bytes      = 0;
        label_overflow  = 1'b0;
    end

    function automatic int unsigned sat_total(int unsigned sum);
        return (sum > NAME_MAX + 1) ? NAME_MAX + 1 : sum;
    endfunction

    task automatic queue_byte(input t_wire_byte b);
        wire_q = {wire_q, b};
    endtask

    task automatic emit_label();
        queue_byte('{code: 8'(label_len), done: 1'b0, length: 8'd0, err: 1'b0});
        for (int i = 0; i < label_len; i++)
            queue_byte('{code: label_chars[i], done: 1'b0, length: 8'd0, err: 1'b0});
        name_bytes = sat_total(name_bytes + label_len + 1);
        label_len  = 0;
    endtask

    task automatic predict_wire(input logic cmd, input logic [7:0] ch);
        logic [7:0] len;
        logic       err;
        if (cmd == CMD_CHAR) begin
            if (ch == DOT_CHAR) begin
                emit_label();
            end else if (label_len < LABEL_MAX) begin
                label_chars[label_len] = ch;
                label_len++;
            end else begin
                label_overflow = 1'b1;
            end
        end else begin
            emit_label();
            name_bytes = sat_total(name_bytes + 1);
            err = label_overflow;
            if (name_bytes > NAME_MAX) begin
                len = 8'(NAME_MAX);
                err = 1'b1;
            end else begin
                len = 8'(name_bytes);
            end
            queue_byte('{code: 8'd0, done: 1'b1, length: len, err: err});
            label_len      = 0;
            name_bytes     = 0;
            label_overflow = 1'b0;
        end
    endtask

    task automatic check_wire();
        t_wire_byte want;
        bytes_checked++;
        if (wire_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result: byte %02h done %0d len %0d err %0d",
                         i_out_byte, i_name_done, i_encoded_length, i_error);
        end else begin
            want = wire_q.pop_front();
            if (i_out_byte !== want.code || i_name_done !== want.done ||
                i_encoded_length !== want.length || i_error !== want.err) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("mismatch: expected %02h/%0d/%0d/%0d got %02h/%0d/%0d/%0d",
                             want.code, want.done, want.length, want.err,
                             i_out_byte, i_name_done, i_encoded_length, i_error);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wire_q.delete();
            label_len      = 0;
            name_bytes     = 0;
            label_overflow = 1'b0;
        end else begin
            if (i_in_valid && !i_in_stall)
                predict_wire(i_command, i_char_code);
            if (i_out_valid && !i_out_stall)
                check_wire();
        end
        o_fail_count    <= fail_count;
        o_expected_left <= wire_q.size();
        o_bytes_checked <= bytes_checked;
    end

endmodule

// ===== test/dns_name_label_encoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dns_name_label_encoder_tb: testbench for the DNS name label encoder
// Feeds directed and random dotted names with random gaps and output
// stalls; a checker beside the block predicts and compares the wire bytes.
// ----------------------------------------------------------------------------
module dns_name_label_encoder_tb;
    import dnle_pkg::*;

    localparam int TOTAL_ITEMS = 230;
    localparam int STALL_LIMIT = 2000;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       command   = CMD_CHAR;
    logic [7:0] char_code = 8'd0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       name_done;
    logic [7:0] encoded_length;
    logic       error;

    int fail_count;
    int expected_left;
    int bytes_checked;
    int item_count = 0;
    int name_count = 0;
    bit no_idle    = 1'b0;
    bit timed_out  = 1'b0;

    dns_name_label_encoder i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_command        (command),
        .i_char_code      (char_code),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_out_byte       (out_byte),
        .o_name_done      (name_done),
        .o_encoded_length (encoded_length),
        .o_error          (error)
    );

    dns_name_wire_checker i_chk (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_command        (command),
        .i_char_code      (char_code),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out_byte       (out_byte),
        .i_name_done      (name_done),
        .i_encoded_length (encoded_length),
        .i_error          (error),
        .o_fail_count     (fail_count),
        .o_expected_left  (expected_left),
        .o_bytes_checked  (bytes_checked)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // receiver: random stall before each result, none in no-idle stretches
    initial begin
        int n;
        forever begin
            n = no_idle ? 0 : $urandom_range(0, 7);
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] ch);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        char_code <= ch;
        do @(posedge clk); while (in_stall);
        item_count++;
        if (cmd == CMD_END)
            name_count++;
    endtask

    task automatic send_end();
        send_item(CMD_END, 8'($urandom_range(0, 255)));
    endtask

    // noisy labels may carry dots, which split them into extra labels
    task automatic send_label(input int len, input bit noisy);
        logic [7:0] ch;
        for (int i = 0; i < len; i++) begin
            ch = 8'($urandom_range(0, 255));
            if (!noisy && ch == DOT_CHAR)
                ch = ch ^ 8'h01;
            send_item(CMD_CHAR, ch);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_left != 0)
            @(posedge clk);
    endtask

    task automatic watch_progress();
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        timed_out = 1'b1;
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        fork
            begin
                int labels;
                int len;
                bit noisy;

                // empty name, then a lone dot (leading and trailing dot)
                send_end();
                send_item(CMD_CHAR, DOT_CHAR);
                send_end();
                // doubled dot between two labels
                send_item(CMD_CHAR, 8'h61);
                send_item(CMD_CHAR, DOT_CHAR);
                send_item(CMD_CHAR, DOT_CHAR);
                send_item(CMD_CHAR, 8'h62);
                send_end();
                // zero and all-ones characters are plain label bytes
                send_item(CMD_CHAR, 8'h00);
                send_item(CMD_CHAR, 8'hFF);
                send_item(CMD_CHAR, DOT_CHAR);
                send_item(CMD_CHAR, 8'h78);
                send_item(CMD_END, DOT_CHAR);
                // full label, then one that drops characters
                send_label(LABEL_MAX_DEF, 1'b0);
                send_end();
                send_label(LABEL_MAX_DEF + 3, 1'b0);
                send_end();
                drain_results();

                while (item_count < TOTAL_ITEMS) begin
                    no_idle = ($urandom_range(0, 4) == 0);
                    noisy   = ($urandom_range(0, 7) == 0);
                    labels  = $urandom_range(0, 4);
                    for (int j = 0; j < labels; j++) begin
                        if ($urandom_range(0, 15) == 0)
                            len = $urandom_range(LABEL_MAX_DEF - 2, LABEL_MAX_DEF + 4);
                        else
                            len = $urandom_range(0, 8);
                        send_label(len, noisy);
                        if (j < labels - 1 || $urandom_range(0, 3) == 0)
                            send_item(CMD_CHAR, DOT_CHAR);
                    end
                    send_end();
                    if ($urandom_range(0, 9) == 0)
                        drain_results();
                end
                no_idle = 1'b0;
                drain_results();
                repeat (10) @(posedge clk);
            end
            watch_progress();
        join_any

        $display("covered %0d items in %0d names, %0d encoded bytes checked",
                 item_count, name_count, bytes_checked);
        if (!timed_out && fail_count == 0 && expected_left == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
